/* design/rvx_pkg.sv */
// Shared constants and types for the RV32I integer execute block.
`default_nettype none
package rvx_pkg;

    localparam int XLEN      = 32;
    localparam int REG_AW    = 5;
    localparam int REG_DEPTH = 32;
    localparam int CFG_AW    = 4;
    localparam int CFG_DW    = 32;

    // Major opcodes
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // ALU funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Store sizes
    localparam logic [2:0] F3_SW = 3'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_PC  = 2'd0;
    localparam logic [1:0] CFG_STACK_TOP = 2'd1;
    localparam logic [1:0] CFG_CODE_SIZE = 2'd2;

    localparam logic [XLEN-1:0] START_PC_RST  = 32'd0;
    localparam logic [XLEN-1:0] STACK_TOP_RST = 32'd8000;
    localparam logic [XLEN-1:0] CODE_SIZE_RST = 32'd10000;

    localparam logic [REG_AW-1:0] SP_IDX = 5'd2;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rvx_wr_t;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              wr_en;
        logic [REG_AW-1:0] wr_addr;
        logic [XLEN-1:0]   wr_data;
        logic              store_valid;
        logic [XLEN-1:0]   store_addr;
        logic [XLEN-1:0]   store_data;
        logic [1:0]        store_size;
        logic              status;
    } rvx_exec_t;

endpackage
`default_nettype wire

/* design/rvx_if.sv */
// Handshake interfaces for the instruction and result channels.
`default_nettype none
interface rvx_instr_if
    import rvx_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rvx_result_if
    import rvx_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] next_pc;
    logic            store_valid;
    logic [XLEN-1:0] store_addr;
    logic [XLEN-1:0] store_data;
    logic [1:0]      store_size;
    logic            status;
    logic            done_res;

    modport source (output valid, output next_pc, output store_valid, output store_addr,
                    output store_data, output store_size, output status,
                    output done_res, input ready);
    modport sink   (input valid, input next_pc, input store_valid, input store_addr,
                    input store_data, input store_size, input status,
                    input done_res, output ready);
endinterface
`default_nettype wire

/* design/rvx_regfile.sv */
// Register file: synchronous two-read one-write memory with reset tracking and bypass.
`default_nettype none
module rvx_regfile
    import rvx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [REG_AW-1:0] rs1_addr,
    input  wire logic [REG_AW-1:0] rs2_addr,
    input  wire rvx_wr_t           wr,
    input  wire logic              sp_load,
    input  wire logic [XLEN-1:0]   stack_top,
    output logic      [XLEN-1:0]   rs1_data,
    output logic      [XLEN-1:0]   rs2_data
);

    logic [XLEN-1:0]      mem [REG_DEPTH];
    logic [XLEN-1:0]      rd1_reg;
    logic [XLEN-1:0]      rd2_reg;
    logic [REG_AW-1:0]    a1_reg;
    logic [REG_AW-1:0]    a2_reg;
    logic [REG_DEPTH-1:0] written_reg;
    logic                 fwd_vld_reg;
    logic [REG_AW-1:0]    fwd_addr_reg;
    logic [XLEN-1:0]      fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd1_reg <= mem[rs1_addr];
            rd2_reg <= mem[rs2_addr];
            a1_reg  <= rs1_addr;
            a2_reg  <= rs2_addr;
        end
    end

    // The bypass register holds the latest write unless a stack_top load clears it,
    // which covers a read issued at the same edge as the write to that entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            fwd_vld_reg <= 1'b0;
        end
        else if (sp_load)
        begin
            written_reg[SP_IDX] <= 1'b0;
            fwd_vld_reg         <= 1'b0;
        end
        else if (wr.en)
        begin
            written_reg[wr.addr] <= 1'b1;
            fwd_vld_reg          <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fwd_addr_reg <= wr.addr;
            fwd_data_reg <= wr.data;
        end
    end

    function automatic logic [XLEN-1:0] pick(input logic [REG_AW-1:0] a,
                                             input logic [XLEN-1:0]   ram);
        logic [XLEN-1:0] v;
        if (fwd_vld_reg && fwd_addr_reg == a)
            v = fwd_data_reg;
        else if (written_reg[a])
            v = ram;
        else if (a == SP_IDX)
            v = stack_top;
        else
            v = '0;
        return v;
    endfunction

    always_comb
    begin
        rs1_data = pick(a1_reg, rd1_reg);
        rs2_data = pick(a2_reg, rd2_reg);
    end

endmodule
`default_nettype wire

/* design/rvx_exec.sv */
// Decode and execute of one instruction: ALU, branch, jump, upper immediates and stores.
`default_nettype none
module rvx_exec
    import rvx_pkg::*;
(
    input  wire logic [XLEN-1:0] instr,
    input  wire logic [XLEN-1:0] pc,
    input  wire logic [XLEN-1:0] rs1_val,
    input  wire logic [XLEN-1:0] rs2_val,
    output rvx_exec_t            ex
);

    logic [6:0]      op;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_s;
    logic [XLEN-1:0] imm_b;
    logic [XLEN-1:0] imm_j;
    logic [XLEN-1:0] imm_u;
    logic [XLEN-1:0] opb;
    logic [4:0]      shamt;
    logic            alt;
    logic [XLEN-1:0] alu_res;
    logic            take;
    logic            ok;
    logic            wr;
    logic [XLEN-1:0] val;
    logic [XLEN-1:0] npc;
    logic [XLEN-1:0] pc4;

    assign op    = instr[6:0];
    assign f3    = instr[14:12];
    assign f7    = instr[31:25];
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
    assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u = {instr[31:12], 12'd0};
    assign opb   = (op == OPC_OP) ? rs2_val : imm_i;
    assign shamt = opb[4:0];
    assign pc4   = pc + 32'd4;

    // Only SUB and SRA/SRAI use the alternate form.
    assign alt = (f7 == F7_ALT) && ((f3 == F3_SR) || (op == OPC_OP && f3 == F3_ADD));

    always_comb
    begin
        case (f3)
            F3_ADD:  alu_res = alt ? rs1_val - opb : rs1_val + opb;
            F3_SLL:  alu_res = rs1_val << shamt;
            F3_SLT:  alu_res = {31'd0, $signed(rs1_val) < $signed(opb)};
            F3_SLTU: alu_res = {31'd0, rs1_val < opb};
            F3_XOR:  alu_res = rs1_val ^ opb;
            F3_SR:   alu_res = alt ? XLEN'($signed(rs1_val) >>> shamt) : rs1_val >> shamt;
            F3_OR:   alu_res = rs1_val | opb;
            default: alu_res = rs1_val & opb;
        endcase
    end

    always_comb
    begin
        case (f3)
            F3_BEQ:  take = (rs1_val == rs2_val);
            F3_BNE:  take = (rs1_val != rs2_val);
            F3_BLT:  take = $signed(rs1_val) < $signed(rs2_val);
            F3_BGE:  take = !($signed(rs1_val) < $signed(rs2_val));
            F3_BLTU: take = rs1_val < rs2_val;
            F3_BGEU: take = rs1_val >= rs2_val;
            default: take = 1'b0;
        endcase
    end

    always_comb
    begin
        ok  = 1'b1;
        wr  = 1'b0;
        val = alu_res;
        npc = pc4;
        ex  = '0;
        unique case (op)
            OPC_OPIMM:
            begin
                if (f3 == F3_SLL)
                    ok = (f7 == F7_BASE);
                else if (f3 == F3_SR)
                    ok = (f7 == F7_BASE) || (f7 == F7_ALT);
                wr = 1'b1;
            end
            OPC_OP:
            begin
                ok = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR));
                wr = 1'b1;
            end
            OPC_LUI:
            begin
                val = imm_u;
                wr  = 1'b1;
            end
            OPC_AUIPC:
            begin
                val = pc + imm_u;
                wr  = 1'b1;
            end
            OPC_BRANCH:
            begin
                ok = !(f3 == 3'd2 || f3 == 3'd3);
                if (take)
                    npc = pc + imm_b;
            end
            OPC_JAL:
            begin
                val = pc4;
                wr  = 1'b1;
                npc = pc + imm_j;
            end
            OPC_STORE:
            begin
                ok = (f3 <= F3_SW);
                ex.store_valid = ok;
                ex.store_addr  = ok ? rs1_val + imm_s : '0;
                ex.store_data  = ok ? rs2_val : '0;
                ex.store_size  = ok ? f3[1:0] : 2'd0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        ex.next_pc = ok ? npc : pc;
        ex.wr_en   = ok && wr && (instr[11:7] != '0);
        ex.wr_addr = instr[11:7];
        ex.wr_data = val;
        ex.status  = !ok;
    end

endmodule
`default_nettype wire

/* design/rv32i_integer_execute.sv */
// Top level of the RV32I integer execute block.
//
// Instructions arrive on the instr channel and each one yields exactly one
// transaction on the result channel: next PC, an optional store request,
// a status bit and the done flag. Both channels use valid/ready.
// The pipeline has two steps. The cycle after an instruction is accepted,
// its source registers come out of the registered read of the register-file
// memory and it executes; the result is loaded into the output register once
// that register is empty or being taken. A new instruction is accepted every
// cycle unless both steps are full and the receiver stalls; a write to the
// register file is bypassed to the instruction that read the same entry at
// that edge.
// If the receiver stalls, the output register holds its transaction, the
// executing instruction waits, and ready on the instr channel drops only
// while both are full. Reset sets the PC to start_pc, x2 to stack_top and all
// other registers to zero at once; no clearing pass is needed. The user must
// write the APB port (start_pc at 0, stack_top at 4, code_size at 8) only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module rv32i_integer_execute
    import rvx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rvx_instr_if.sink              instr,
    rvx_result_if.source           result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    logic [XLEN-1:0] start_pc_reg;
    logic [XLEN-1:0] stack_top_reg;
    logic [XLEN-1:0] code_size_reg;
    logic [XLEN-1:0] pc_reg;
    logic            ex_vld_reg;
    logic [XLEN-1:0] ex_instr_reg;
    logic            out_vld_reg;
    logic [XLEN-1:0] out_npc_reg;
    logic            out_st_reg;
    logic [XLEN-1:0] out_saddr_reg;
    logic [XLEN-1:0] out_sdata_reg;
    logic [1:0]      out_ssize_reg;
    logic            out_status_reg;
    logic            out_done_reg;

    logic            in_acc;
    logic            ex_go;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic [XLEN-1:0] rs1_val;
    logic [XLEN-1:0] rs2_val;
    rvx_exec_t       ex;
    rvx_wr_t         wr;
    logic            done_next;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        unique case (cfg_idx)
            CFG_START_PC:  prdata = start_pc_reg;
            CFG_STACK_TOP: prdata = stack_top_reg;
            CFG_CODE_SIZE: prdata = code_size_reg;
            default:       prdata = '0;
        endcase
    end

    assign ex_go        = ex_vld_reg && (!out_vld_reg || result.ready);
    assign instr.ready  = !ex_vld_reg || ex_go;
    assign in_acc       = instr.valid && instr.ready;

    rvx_regfile u_rf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_acc),
        .rs1_addr  (instr.instruction[19:15]),
        .rs2_addr  (instr.instruction[24:20]),
        .wr        (wr),
        .sp_load   (cfg_wr && cfg_idx == CFG_STACK_TOP),
        .stack_top (stack_top_reg),
        .rs1_data  (rs1_val),
        .rs2_data  (rs2_val)
    );

    rvx_exec u_exec (
        .instr   (ex_instr_reg),
        .pc      (pc_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .ex      (ex)
    );

    assign wr.en   = ex_go && ex.wr_en;
    assign wr.addr = ex.wr_addr;
    assign wr.data = ex.wr_data;

    // With a code size below four the subtraction wraps, so that case is done.
    assign done_next = (code_size_reg < 32'd4) || (ex.next_pc >= code_size_reg - 32'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg  <= START_PC_RST;
            stack_top_reg <= STACK_TOP_RST;
            code_size_reg <= CODE_SIZE_RST;
            pc_reg        <= START_PC_RST;
            ex_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    CFG_START_PC:
                    begin
                        start_pc_reg <= pwdata;
                        pc_reg       <= pwdata;
                    end
                    CFG_STACK_TOP: stack_top_reg <= pwdata;
                    CFG_CODE_SIZE: code_size_reg <= pwdata;
                    default:       ;
                endcase
            end
            else if (ex_go)
            begin
                pc_reg <= ex.next_pc;
            end
            ex_vld_reg <= in_acc || (ex_vld_reg && !ex_go);
            if (ex_go)
                out_vld_reg <= 1'b1;
            else if (result.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            ex_instr_reg <= instr.instruction;
        if (ex_go)
        begin
            out_npc_reg    <= ex.next_pc;
            out_st_reg     <= ex.store_valid;
            out_saddr_reg  <= ex.store_addr;
            out_sdata_reg  <= ex.store_data;
            out_ssize_reg  <= ex.store_size;
            out_status_reg <= ex.status;
            out_done_reg   <= done_next;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.next_pc     = out_npc_reg;
    assign result.store_valid = out_st_reg;
    assign result.store_addr  = out_saddr_reg;
    assign result.store_data  = out_sdata_reg;
    assign result.store_size  = out_ssize_reg;
    assign result.status      = out_status_reg;
    assign result.done_res    = out_done_reg;

endmodule
`default_nettype wire

/* dv/tb_rv32i_integer_execute.sv */
// Self-checking testbench for rv32i_integer_execute: directed and random instructions vs predictor.
module tb_rv32i_integer_execute;
    import rvx_pkg::*;

    // Opcodes the block must reject
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [2:0] F3_SB = 3'd0;
    localparam logic [2:0] F3_SH = 3'd1;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    localparam int RANDOM_SEGMENTS = 6;
    localparam int SEGMENT_ITEMS   = 300;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int send_idle_pct;
    int recv_idle_pct;
    int n_settings;

    rvx_instr_if  instr_ch();
    rvx_result_if result_ch();

    rv32i_integer_execute i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    typedef struct packed {
        logic [XLEN-1:0] next_pc;
        logic            store_valid;
        logic [XLEN-1:0] store_addr;
        logic [XLEN-1:0] store_data;
        logic [1:0]      store_size;
        logic            status;
        logic            done_res;
    } exec_result_t;

    // Architectural copy of the PC and register file; every accepted instruction
    // is executed here and its outcome queued until the block returns it.
    class rv32i_exec_scoreboard;
        logic [XLEN-1:0] pc;
        logic [XLEN-1:0] code_size;
        logic [XLEN-1:0] regs [REG_DEPTH];
        exec_result_t    pending_results [$];
        int n_items;
        int n_stores;
        int n_unsupported;
        int n_done;
        int n_errors;

        function new();
            pc        = START_PC_RST;
            code_size = CODE_SIZE_RST;
            foreach (regs[i])
                regs[i] = '0;
            regs[SP_IDX] = STACK_TOP_RST;
        endfunction

        function void write_register(logic [1:0] idx, logic [XLEN-1:0] value);
            case (idx)
                CFG_START_PC:  pc = value;
                CFG_STACK_TOP: regs[SP_IDX] = value;
                CFG_CODE_SIZE: code_size = value;
                default: ;
            endcase
        endfunction

        function logic [XLEN-1:0] alu_result(logic [2:0] f3, logic alt,
                                             logic [XLEN-1:0] a, logic [XLEN-1:0] b);
            case (f3)
                F3_ADD:  return alt ? a - b : a + b;
                F3_SLL:  return a << b[4:0];
                F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
                F3_XOR:  return a ^ b;
                F3_SR:
                    if (alt)
                        return $signed(a) >>> b[4:0];
                    else
                        return a >> b[4:0];
                F3_OR:   return a | b;
                default: return a & b;
            endcase
        endfunction

        function void note_instruction(logic [XLEN-1:0] w);
            logic [6:0]      op;
            logic [6:0]      f7;
            logic [2:0]      f3;
            logic [4:0]      rd;
            logic [4:0]      rs1;
            logic [4:0]      rs2;
            logic [XLEN-1:0] a;
            logic [XLEN-1:0] b;
            logic [XLEN-1:0] imm;
            logic [XLEN-1:0] val;
            logic [XLEN-1:0] npc;
            logic            ok;
            logic            wr;
            logic            take;
            exec_result_t    r;

            op  = w[6:0];
            rd  = w[11:7];
            f3  = w[14:12];
            rs1 = w[19:15];
            rs2 = w[24:20];
            f7  = w[31:25];
            a   = regs[rs1];
            b   = regs[rs2];
            npc = pc + 32'd4;
            val = '0;
            ok  = 1'b1;
            wr  = 1'b0;
            take = 1'b0;
            r   = '0;

            case (op)
                OPC_OPIMM:
                begin
                    imm = {{20{w[31]}}, w[31:20]};
                    if (f3 == F3_SLL)
                        ok = (f7 == F7_BASE);
                    else if (f3 == F3_SR)
                        ok = (f7 == F7_BASE || f7 == F7_ALT);
                    val = alu_result(f3, f3 == F3_SR && f7 == F7_ALT, a, imm);
                    wr  = 1'b1;
                end
                OPC_OP:
                begin
                    ok  = (f7 == F7_BASE) || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR));
                    val = alu_result(f3, f7 == F7_ALT, a, b);
                    wr  = 1'b1;
                end
                OPC_LUI:
                begin
                    val = {w[31:12], 12'b0};
                    wr  = 1'b1;
                end
                OPC_AUIPC:
                begin
                    val = pc + {w[31:12], 12'b0};
                    wr  = 1'b1;
                end
                OPC_BRANCH:
                begin
                    imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = ($signed(a) < $signed(b));
                        F3_BGE:  take = !($signed(a) < $signed(b));
                        F3_BLTU: take = (a < b);
                        F3_BGEU: take = (a >= b);
                        default: ok = 1'b0;
                    endcase
                    if (take)
                        npc = pc + imm;
                end
                OPC_JAL:
                begin
                    imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                    val = pc + 32'd4;
                    wr  = 1'b1;
                    npc = pc + imm;
                end
                OPC_STORE:
                begin
                    if (f3 <= F3_SW)
                    begin
                        imm = {{20{w[31]}}, w[31:25], w[11:7]};
                        r.store_valid = 1'b1;
                        r.store_addr  = a + imm;
                        r.store_data  = b;
                        r.store_size  = f3[1:0];
                    end
                    else
                        ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase

            // A rejected instruction leaves all state alone and reports no store.
            if (!ok)
            begin
                npc = pc;
                wr  = 1'b0;
                r   = '0;
            end
            if (wr && rd != 5'd0)
                regs[rd] = val;
            pc = npc;

            r.next_pc  = npc;
            r.status   = !ok;
            r.done_res = (code_size < 32'd4) || (npc >= code_size - 32'd4);
            pending_results.push_back(r);

            n_items++;
            n_stores      += r.store_valid;
            n_unsupported += r.status;
            n_done        += r.done_res;
        endfunction

        function void compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction with next_pc %h", got.next_pc);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("next_pc", want.next_pc, got.next_pc);
            compare_field("store_valid", want.store_valid, got.store_valid);
            compare_field("store_addr", want.store_addr, got.store_addr);
            compare_field("store_data", want.store_data, got.store_data);
            compare_field("store_size", want.store_size, got.store_size);
            compare_field("status", want.status, got.status);
            compare_field("done_res", want.done_res, got.done_res);
        endfunction
    endclass

    rv32i_exec_scoreboard exec_sb = new();

    // Instruction encoders
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] off, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
        return {imm, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    // Mostly the low registers, so that results feed later instructions.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(3) == 0)
            return 5'($urandom_range(31));
        return 5'($urandom_range(7));
    endfunction

    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(7))
            0: return 12'h7FF;
            1: return 12'h800;
            2: return 12'hFFF;
            3: return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [2:0]  f3;
        int unsigned pick;
        int          off;

        w    = $urandom;
        f3   = w[14:12];
        pick = $urandom_range(99);
        if (pick < 6)
            return w;
        w[11:7]  = pick_reg();
        w[19:15] = pick_reg();
        w[24:20] = pick_reg();
        if (pick < 10)
        begin
            case ($urandom_range(3))
                0: w[6:0] = OPC_LOAD;
                1: w[6:0] = OPC_JALR;
                2: w[6:0] = OPC_SYSTEM;
                default: w[6:0] = OPC_FENCE;
            endcase
        end
        else if (pick < 30)
        begin
            w[6:0] = OPC_OP;
            if ($urandom_range(9) != 0)
                w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
        end
        else if (pick < 55)
        begin
            w[6:0] = OPC_OPIMM;
            if (f3 == F3_SLL || f3 == F3_SR)
            begin
                if ($urandom_range(9) != 0)
                    w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
            end
            else
                w[31:20] = pick_imm12();
        end
        else if (pick < 62)
            w[6:0] = OPC_LUI;
        else if (pick < 67)
            w[6:0] = OPC_AUIPC;
        else if (pick < 81)
        begin
            // Short hops keep the PC near the end-of-code boundary.
            off = 4 * (int'($urandom_range(32)) - 16);
            if ($urandom_range(7) == 0)
                off = int'($urandom);
            w = enc_b(13'(off), w[24:20], w[19:15], f3);
        end
        else if (pick < 86)
        begin
            off = 4 * (int'($urandom_range(64)) - 32);
            if ($urandom_range(7) == 0)
                off = int'($urandom);
            w = enc_j(21'(off), w[11:7]);
        end
        else
        begin
            if ($urandom_range(7) == 0)
                f3 = 3'(3 + $urandom_range(4));
            else
                f3 = 3'($urandom_range(2));
            w = enc_s(pick_imm12(), w[24:20], w[19:15], f3);
        end
        return w;
    endfunction

    // All driving tasks start and end just after a falling edge.
    task automatic send_instruction(logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.instruction <= w;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        instr_ch.valid <= 1'b0;
        while (exec_sb.pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        exec_sb.write_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        exec_result_t got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.next_pc     = result_ch.next_pc;
                got.store_valid = result_ch.store_valid;
                got.store_addr  = result_ch.store_addr;
                got.store_data  = result_ch.store_data;
                got.store_size  = result_ch.store_size;
                got.status      = result_ch.status;
                got.done_res    = result_ch.done_res;
                exec_sb.check_result(got);
            end
            if (instr_ch.valid && instr_ch.ready)
                exec_sb.note_instruction(instr_ch.instruction);
        end
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [31:0] directed [$];
        logic [31:0] new_start;
        logic [31:0] new_stack;
        logic [31:0] new_code;

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        instr_ch.valid       = 1'b0;
        instr_ch.instruction = '0;
        send_idle_pct        = 26;
        recv_idle_pct        = 64;
        n_settings           = 1;

        directed = {
            enc_u(20'h80000, 5'd1, OPC_LUI),
            enc_u(20'hFFFFF, 5'd16, OPC_AUIPC),
            enc_i(12'h800, 5'd0, F3_ADD, 5'd3, OPC_OPIMM),
            enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OPC_OPIMM),
            enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd5),
            enc_r(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd6),
            enc_r(F7_BASE, 5'd4, 5'd3, F3_SLL, 5'd7),
            enc_r(F7_BASE, 5'd4, 5'd1, F3_SLT, 5'd8),
            enc_r(F7_BASE, 5'd4, 5'd1, F3_SLTU, 5'd9),
            enc_r(F7_ALT, 5'd4, 5'd1, F3_SR, 5'd10),
            enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd11, OPC_OPIMM),
            enc_i(12'hFFF, 5'd3, F3_SLTU, 5'd12, OPC_OPIMM),
            enc_i(12'h0F0, 5'd3, F3_AND, 5'd13, OPC_OPIMM),
            enc_i(12'h7FF, 5'd4, F3_ADD, 5'd0, OPC_OPIMM),
            enc_b(13'd8, 5'd0, 5'd5, F3_BEQ),
            enc_b(-13'sd8, 5'd0, 5'd1, F3_BNE),
            enc_b(13'd16, 5'd4, 5'd1, F3_BLT),
            enc_b(13'd16, 5'd4, 5'd1, F3_BGE),
            enc_b(13'd32, 5'd1, 5'd4, F3_BLTU),
            enc_b(13'h1000, 5'd4, 5'd1, F3_BGEU),
            enc_j(21'h0FFFFE, 5'd1),
            enc_s(12'h800, 5'd1, 5'd3, F3_SB),
            enc_s(12'h7FF, 5'd2, 5'd1, F3_SH),
            enc_s(12'h001, 5'd16, 5'd4, F3_SW),
            enc_i(12'h000, 5'd1, F3_SLT, 5'd5, OPC_LOAD),
            enc_i(12'h000, 5'd1, F3_ADD, 5'd1, OPC_JALR),
            enc_i(12'h000, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM),
            enc_r(F7_MULDIV, 5'd2, 5'd1, F3_ADD, 5'd5)
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_instruction(directed[i]);
        wait_for_results();

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            case (seg)
                0:
                begin
                    new_start = 32'hFFFF_FFF0;
                    new_stack = 32'hFFFF_FFFF;
                    new_code  = 32'h0000_0000;
                end
                1:
                begin
                    new_start = 32'h0000_1000;
                    new_stack = 32'h0000_0000;
                    new_code  = 32'h0000_1100;
                end
                2:
                begin
                    new_start = 32'hFFFF_FF00;
                    new_stack = $urandom;
                    new_code  = 32'hFFFF_FFFF;
                end
                3:
                begin
                    new_start = $urandom & ~32'd3;
                    new_stack = $urandom;
                    new_code  = 32'd3;
                end
                default:
                begin
                    new_start = $urandom & ~32'd3;
                    new_stack = $urandom;
                    new_code  = new_start + 4 * $urandom_range(64, 1);
                end
            endcase
            apb_write(CFG_START_PC, new_start);
            apb_write(CFG_STACK_TOP, new_stack);
            apb_write(CFG_CODE_SIZE, new_code);
            // The unused slot must not disturb any register.
            if (seg == 0)
                apb_write(CFG_UNMAPPED, $urandom);
            n_settings++;

            repeat (SEGMENT_ITEMS)
                send_instruction(random_instruction());
            wait_for_results();
        end

        repeat (4) @(negedge clk);

        $display("Executed %0d instructions under %0d register settings and three stall patterns.",
                 exec_sb.n_items, n_settings);
        $display("Of these, %0d were stores, %0d were rejected and %0d reported done.",
                 exec_sb.n_stores, exec_sb.n_unsupported, exec_sb.n_done);
        if (exec_sb.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
